[src/tkarb_pkg.sv]
`default_nettype none

package tkarb_pkg;

   // widths fixed by the stream fields
   localparam int unsigned CMD_W       = 3;
   localparam int unsigned NODE_W      = 3;
   localparam int unsigned SEQ_FIELD_W = 16;
   localparam int unsigned CLASS_W     = 3;
   localparam int unsigned REQ_DATA_W  = 24;
   localparam int unsigned RSP_DATA_W  = 24;

   // class held by an entry with no real request behind it
   localparam logic [CLASS_W-1:0] CLASS_IDLE = 3'd5;

   typedef enum logic [CMD_W-1:0] {
      CMD_REMOTE = 3'd0,
      CMD_LOCAL  = 3'd1,
      CMD_MERGE  = 3'd2,
      CMD_MARK   = 3'd3,
      CMD_SELECT = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_HOLD
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      logic    upd;
      cmd_type cmd;
   } ctl_type;

   // candidate handed from cell to cell
   typedef struct packed {
      logic               found;
      logic [CLASS_W-1:0] cls;
   } cand_type;

endpackage

`default_nettype wire

[src/tkarb_cell.sv]
`default_nettype none

module tkarb_cell #(
   parameter int unsigned INDEX    = 0,
   parameter int unsigned SEQ_BITS = 16,
   parameter int unsigned IDX_W    = 3
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tkarb_pkg::ctl_type             ctl,
   input  wire logic                           hit,
   input  wire logic                           is_me,
   input  wire logic [SEQ_BITS-1:0]            seq_in,
   input  wire logic [tkarb_pkg::CLASS_W-1:0]  prio,
   input  wire logic [SEQ_BITS-1:0]            own_new,
   input  wire logic [SEQ_BITS-1:0]            own_cur,
   output logic                                newer,
   input  wire tkarb_pkg::cand_type            cand_in,
   input  wire logic [SEQ_BITS-1:0]            cand_seq_in,
   input  wire logic [IDX_W-1:0]               cand_idx_in,
   output tkarb_pkg::cand_type                 cand_out,
   output logic [SEQ_BITS-1:0]                 cand_seq_out,
   output logic [IDX_W-1:0]                    cand_idx_out
);
   import tkarb_pkg::*;

   logic [SEQ_BITS-1:0] rseq_ff, rseq_in;
   logic [CLASS_W-1:0]  cls_ff, cls_in;
   logic [SEQ_BITS-1:0] served_ff, served_in;
   cand_type            cand_ff, cand_in_next;
   logic [SEQ_BITS-1:0] cseq_ff, cseq_in;
   logic [IDX_W-1:0]    cidx_ff, cidx_in;
   logic                take;
   logic                pending;
   logic                better;

   // entry update
   always_comb begin
      newer     = seq_in > served_ff;
      take      = (prio < cls_ff) || (rseq_ff <= served_ff) ||
                  ((prio == cls_ff) && (seq_in > rseq_ff));
      rseq_in   = rseq_ff;
      cls_in    = cls_ff;
      served_in = served_ff;
      if (ctl.upd) begin
         case (ctl.cmd)
            CMD_REMOTE: begin
               if (hit && newer && take) begin
                  rseq_in = seq_in;
                  cls_in  = prio;
               end
            end
            CMD_LOCAL: begin
               if (is_me) begin
                  rseq_in = own_new;
                  cls_in  = prio;
               end
            end
            CMD_MERGE: begin
               if (hit && newer) begin
                  served_in = seq_in;
               end
            end
            CMD_MARK: begin
               if (is_me) begin
                  served_in = own_cur;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // compare against the candidate from the left neighbor
   always_comb begin
      pending = rseq_ff > served_ff;
      better  = pending && (!cand_in.found || (cls_ff < cand_in.cls) ||
                ((cls_ff == cand_in.cls) && (rseq_ff < cand_seq_in)));
      if (better) begin
         cand_in_next.found = 1'b1;
         cand_in_next.cls   = cls_ff;
         cseq_in            = rseq_ff;
         cidx_in            = IDX_W'(INDEX);
      end else begin
         cand_in_next = cand_in;
         cseq_in      = cand_seq_in;
         cidx_in      = cand_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rseq_ff   <= (INDEX == 0) ? SEQ_BITS'(1) : '0;
         cls_ff    <= (INDEX == 0) ? CLASS_IDLE : '0;
         served_ff <= '0;
         cand_ff   <= '0;
      end else begin
         rseq_ff   <= rseq_in;
         cls_ff    <= cls_in;
         served_ff <= served_in;
         cand_ff   <= cand_in_next;
      end
   end

   always_ff @(posedge clock) begin
      cseq_ff <= cseq_in;
      cidx_ff <= cidx_in;
   end

   assign cand_out     = cand_ff;
   assign cand_seq_out = cseq_ff;
   assign cand_idx_out = cidx_ff;

endmodule

`default_nettype wire

[src/token_request_priority_arbiter.sv]
// a request updates the tables on its transfer; no new request is taken until
// its result is loaded from the selection sweep, which ripples one candidate
//    through the row of NODES cells, one cell per cycle
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active high): tables to zero except entry 0 (seq 1,
//    class 5), own sequence 1, highest seen 0, self node 0, no result pending
`default_nettype none

module token_request_priority_arbiter #(
   parameter int unsigned NODES    = 8,
   parameter int unsigned SEQ_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration: self node index
   input  wire logic                              csr_wen,
   input  wire logic [tkarb_pkg::NODE_W-1:0]      csr_wdata,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // node [2:0], seq [18:3], prio [21:19], zero [23:22]
   input  wire logic [tkarb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd [2:0]
   input  wire logic [tkarb_pkg::CMD_W-1:0]       req_tuser,
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // winner [2:0], pass_token [3], any_pending [4], stale [5],
   // own_seq [21:6], zero [23:22]
   output logic [tkarb_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import tkarb_pkg::*;

   localparam int unsigned IDX_W = $clog2(NODES);
   localparam int unsigned CNT_W = $clog2(NODES + 1);
   localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};

   // unpacked request fields
   logic [NODE_W-1:0]      req_node;
   logic [SEQ_FIELD_W-1:0] req_seq;
   logic [CLASS_W-1:0]     req_prio;
   cmd_type                req_cmd;
   logic [SEQ_BITS-1:0]    seq_m;

   assign req_node = req_tdata[2:0];
   assign req_seq  = req_tdata[18:3];
   assign req_prio = req_tdata[21:19];
   assign req_cmd  = cmd_type'(req_tuser);
   // sequence taken modulo 2^SEQ_BITS
   assign seq_m    = SEQ_BITS'(req_seq);

   // control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NODE_W-1:0]   self_ff, self_in;
   logic [SEQ_BITS-1:0] hs_ff, hs_in;
   logic [SEQ_BITS-1:0] own_ff, own_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                stale_ff, stale_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic load;
   logic sweep_done;

   assign req_accept = req_tvalid && req_tready;
   assign sweep_done = cnt_ff == CNT_W'(NODES);

   // this node, falls back to node 0 when the self index is out of range
   logic             self_ok;
   logic [IDX_W-1:0] me_idx;
   logic             node_ok;
   logic [IDX_W-1:0] node_idx;

   assign self_ok  = 32'(self_ff) < NODES;
   assign me_idx   = self_ok ? IDX_W'(self_ff) : '0;
   assign node_ok  = 32'(req_node) < NODES;
   assign node_idx = IDX_W'(req_node);

   // saturating increment of the highest seen sequence
   logic [SEQ_BITS-1:0] hs_inc;
   assign hs_inc = (hs_ff == SEQ_MAX) ? hs_ff : hs_ff + SEQ_BITS'(1);

   // cell row
   ctl_type             ctl;
   logic [NODES-1:0]    hit_sel;
   logic [NODES-1:0]    me_sel;
   logic [NODES-1:0]    newer_vec;
   cand_type            cand    [NODES+1];
   logic [SEQ_BITS-1:0] cand_seq[NODES+1];
   logic [IDX_W-1:0]    cand_idx[NODES+1];

   assign ctl.upd = req_accept;
   assign ctl.cmd = req_cmd;

   // the row starts with no candidate
   assign cand[0]     = '0;
   assign cand_seq[0] = '0;
   assign cand_idx[0] = '0;

   for (genvar i = 0; i < NODES; i++) begin : g_cell
      assign hit_sel[i] = node_ok && (node_idx == IDX_W'(i));
      assign me_sel[i]  = me_idx == IDX_W'(i);

      tkarb_cell #(
         .INDEX    (i),
         .SEQ_BITS (SEQ_BITS),
         .IDX_W    (IDX_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .hit          (hit_sel[i]),
         .is_me        (me_sel[i]),
         .seq_in       (seq_m),
         .prio         (req_prio),
         .own_new      (hs_inc),
         .own_cur      (own_ff),
         .newer        (newer_vec[i]),
         .cand_in      (cand[i]),
         .cand_seq_in  (cand_seq[i]),
         .cand_idx_in  (cand_idx[i]),
         .cand_out     (cand[i+1]),
         .cand_seq_out (cand_seq[i+1]),
         .cand_idx_out (cand_idx[i+1])
      );
   end

   // newer than the addressed node's served value
   logic newer_hit;
   assign newer_hit = |(newer_vec & hit_sel);

   // global sequence state and stale flag, updated on the request transfer
   always_comb begin
      hs_in    = hs_ff;
      own_in   = own_ff;
      stale_in = stale_ff;
      if (req_accept) begin
         stale_in = 1'b0;
         case (req_cmd)
            CMD_REMOTE: begin
               if (node_ok) begin
                  if (newer_hit) begin
                     if (seq_m > hs_ff) begin
                        hs_in = seq_m;
                     end
                  end else begin
                     stale_in = 1'b1;
                  end
               end
            end
            CMD_LOCAL: begin
               hs_in  = hs_inc;
               own_in = hs_inc;
            end
            default: begin
            end
         endcase
      end
   end

   // configuration write
   assign self_in = csr_wen ? csr_wdata : self_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = load ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = 1'b0;
      load       = 1'b0;
      cnt_in     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
         end
         ST_SWEEP: begin
            // candidate at the end of the row is final once every cell
            // has seen the updated tables
            if (sweep_done) begin
               load = !rsp_valid_ff || rsp_tready;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_HOLD: begin
            load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // result assembly from the last cell's candidate
   logic [IDX_W-1:0] win_idx;
   logic             any_pend;

   assign any_pend = cand[NODES].found;
   assign win_idx  = any_pend ? cand_idx[NODES] : me_idx;

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[2:0]   = NODE_W'(win_idx);
      rsp_data_in[3]     = win_idx != me_idx;
      rsp_data_in[4]     = any_pend;
      rsp_data_in[5]     = stale_ff;
      rsp_data_in[21:6]  = SEQ_FIELD_W'(own_ff);
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         self_ff      <= '0;
         hs_ff        <= '0;
         own_ff       <= SEQ_BITS'(1);
         rsp_valid_ff <= 1'b0;
         stale_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         self_ff      <= self_in;
         hs_ff        <= hs_in;
         own_ff       <= own_in;
         rsp_valid_ff <= rsp_valid_in;
         stale_ff     <= stale_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a transfer always starts a fresh sweep
   a_accept_sweep: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SWEEP) && (cnt_ff == '0))
      else $error("sweep did not start after request transfer");

   // exactly one cell plays this node, whatever the self index
   a_me_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(me_sel))
      else $error("self selection not one-hot");

   // a command addresses at most one cell
   a_hit_onehot0: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_sel))
      else $error("node selection hits several cells");

   // sweep counter never runs past the row length
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= CNT_W'(NODES)))
      else $error("sweep counter out of range");

   // result register only loads from a finished sweep
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      load |-> sweep_done)
      else $error("result loaded before sweep end");

endmodule

`default_nettype wire
